### sv/dns_response_ipv4_extractor_unit_assert.svh
// Assertion macros for the DNS response IPv4 extractor.
// Used by the port-level checker; no other dependencies.
`ifndef DNS_RESPONSE_IPV4_EXTRACTOR_UNIT_ASSERT_SVH
`define DNS_RESPONSE_IPV4_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/dre_pkg.sv
// Package for the DNS response IPv4 extractor: parse phases, state and result types.
// No dependencies; imported by the parser, result register and top level.
package dre_pkg;

	localparam int FC_W = 4;

	localparam logic [FC_W-1:0] HDR_LAST = FC_W'(11);
	localparam logic [FC_W-1:0] QF_LAST  = FC_W'(3);
	localparam logic [FC_W-1:0] AF_LAST  = FC_W'(9);
	localparam logic [FC_W-1:0] ADDR_BYTES = FC_W'(4);
	localparam logic [7:0]      PTR_MARK = 8'd192;
	localparam logic [15:0]     TYPE_A   = 16'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_QNAME  = 3'd1,
		PH_QFIXED = 3'd2,
		PH_ANAME  = 3'd3,
		PH_AFIXED = 3'd4,
		PH_ADATA  = 3'd5,
		PH_DONE   = 3'd6
	} dre_phase_t;

	typedef struct packed {
		dre_phase_t      phase;
		logic [FC_W-1:0] fc;
		logic [5:0]      label_left;
		logic [15:0]     q_left;
		logic [15:0]     a_left;
		logic [15:0]     data_left;
		logic [15:0]     kind;
		logic [31:0]     cand;
		logic [31:0]     kept;
		logic            found;
	} dre_state_t;

	localparam dre_state_t STATE_RESET = '{
		PH_HEADER, {FC_W{1'b0}}, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0
	};

	typedef struct packed {
		logic        found;
		logic [31:0] addr;
		logic        status;
	} dre_result_t;

endpackage

### sv/dre_parser.sv
// Byte-at-a-time DNS response parser state and its per-byte update.
// Depends on dre_pkg.
module dre_parser import dre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_value,
	input  logic        is_last,
	output dre_result_t result
);

	dre_state_t st_q;
	dre_state_t nx;

	logic            name_done;
	logic [FC_W-1:0] name_fc;
	logic [5:0]      name_label;
	logic            do_finish;
	logic [15:0]     a_dec;

	function automatic dre_phase_t after_q(input logic [15:0] q, input logic [15:0] a);
		dre_phase_t p;
		if (q != 16'd0)
			p = PH_QNAME;
		else if (a != 16'd0)
			p = PH_ANAME;
		else
			p = PH_DONE;
		return p;
	endfunction

	// name byte: labels, terminating zero, or two-byte pointer
	always_comb begin
		name_done  = 1'b0;
		name_fc    = st_q.fc;
		name_label = st_q.label_left;
		if (st_q.fc == FC_W'(1)) begin
			name_done = 1'b1;
			name_fc   = '0;
		end else if (st_q.label_left != 6'd0) begin
			name_label = st_q.label_left - 6'd1;
		end else if (byte_value == 8'd0) begin
			name_done = 1'b1;
		end else if (byte_value >= PTR_MARK) begin
			name_fc = FC_W'(1);
		end else begin
			name_label = byte_value[5:0];
		end
	end

	always_comb begin
		nx        = st_q;
		do_finish = 1'b0;
		case (st_q.phase)
			PH_HEADER: begin
				case (st_q.fc)
					FC_W'(4): nx.q_left = {byte_value, 8'h00};
					FC_W'(5): nx.q_left[7:0] = byte_value;
					FC_W'(6): nx.a_left = {byte_value, 8'h00};
					FC_W'(7): nx.a_left[7:0] = byte_value;
					default: ;
				endcase
				if (st_q.fc == HDR_LAST) begin
					nx.fc    = '0;
					nx.phase = after_q(nx.q_left, nx.a_left);
				end else begin
					nx.fc = st_q.fc + FC_W'(1);
				end
			end
			PH_QNAME, PH_ANAME: begin
				nx.fc         = name_fc;
				nx.label_left = name_label;
				if (name_done) begin
					nx.fc    = '0;
					nx.phase = (st_q.phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
				end
			end
			PH_QFIXED: begin
				if (st_q.fc == QF_LAST) begin
					nx.fc     = '0;
					nx.q_left = st_q.q_left - 16'd1;
					nx.phase  = after_q(nx.q_left, st_q.a_left);
				end else begin
					nx.fc = st_q.fc + FC_W'(1);
				end
			end
			PH_AFIXED: begin
				case (st_q.fc)
					FC_W'(0): nx.kind = {byte_value, 8'h00};
					FC_W'(1): nx.kind[7:0] = byte_value;
					FC_W'(8): nx.data_left = {byte_value, 8'h00};
					FC_W'(9): nx.data_left[7:0] = byte_value;
					default: ;
				endcase
				if (st_q.fc == AF_LAST) begin
					nx.fc   = '0;
					nx.cand = 32'd0;
					if (nx.data_left == 16'd0)
						do_finish = 1'b1;
					else
						nx.phase = PH_ADATA;
				end else begin
					nx.fc = st_q.fc + FC_W'(1);
				end
			end
			PH_ADATA: begin
				if (st_q.kind == TYPE_A && st_q.fc < ADDR_BYTES) begin
					case (st_q.fc[1:0])
						2'd0: nx.cand[31:24] = byte_value;
						2'd1: nx.cand[23:16] = byte_value;
						2'd2: nx.cand[15:8]  = byte_value;
						default: nx.cand[7:0] = byte_value;
					endcase
				end
				// saturate: only the first four data bytes matter
				if (st_q.fc < ADDR_BYTES)
					nx.fc = st_q.fc + FC_W'(1);
				nx.data_left = st_q.data_left - 16'd1;
				if (nx.data_left == 16'd0)
					do_finish = 1'b1;
			end
			default: ;
		endcase

		// close one answer record
		a_dec = st_q.a_left - 16'd1;
		if (do_finish) begin
			if (nx.kind == TYPE_A) begin
				nx.kept  = nx.cand;
				nx.found = 1'b1;
			end
			nx.a_left = a_dec;
			nx.phase  = (a_dec != 16'd0) ? PH_ANAME : PH_DONE;
			nx.fc     = '0;
		end
	end

	assign result.found  = nx.found;
	assign result.addr   = nx.found ? nx.kept : 32'd0;
	assign result.status = (nx.phase != PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step) begin
			st_q <= is_last ? STATE_RESET : nx;
		end
	end

endmodule

### sv/dre_result_reg.sv
// Result register for the DNS response IPv4 extractor: holds one result item.
// Depends on dre_pkg.
module dre_result_reg import dre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  dre_result_t result_in,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        free,
	output logic        found,
	output logic [31:0] ipv4_address,
	output logic        status
);

	logic        out_valid_q;
	dre_result_t res_q;

	// room for a new result: empty, or current one leaves this cycle
	assign free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result_in;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = res_q.found;
	assign ipv4_address = res_q.addr;
	assign status       = res_q.status;

endmodule

### sv/dns_response_ipv4_extractor_unit.sv
// Top level of the DNS response IPv4 extractor: input register, parser, result register.
// Depends on dre_pkg, dre_parser and dre_result_reg.
//
// Usage:
//   Input channel (in_valid / in_stall, byte_value, is_last) carries one packet
//   byte per item, in order; is_last marks the final byte of a packet.
//   Output channel (out_valid / out_stall, found, ipv4_address, status) carries
//   one result item per packet, produced from the byte that has is_last set.
//   An item moves at a rising edge where valid is high and stall is low.
// Throughput: one byte per cycle, back to back across packets, unless out_stall holds a last byte.
// Result path: an accepted last byte is held in the input register, and the result
//   register loads the packet's outcome when that byte advances to the parser.
// Rate is set by the input register feeding the parser's state update; every
//   byte, including a packet's last, completes in that single update.
// Reset: arst_n clears the parser to the header phase and empties the input
//   and result registers; no cleanup pass is needed.
// Stall: while a result waits under out_stall, non-last bytes keep flowing;
//   only a following last byte holds in the input register, and in_stall
//   rises until the waiting result item is taken.
module dns_response_ipv4_extractor_unit import dre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] ipv4_address,
	output logic        status
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic        accept;
	logic        out_free;
	dre_result_t result;

	// a non-last byte always advances; a last byte needs room in the result register
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// input register: hold the item while stalled, refill as it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_value;
			last_s1 <= is_last;
		end
	end

	// parser advances one byte per accepted item and restarts after the last
	dre_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.byte_value (byte_s1),
		.is_last    (last_s1),
		.result     (result)
	);

	// result register: load the packet's outcome on its last byte
	dre_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv_s1 && last_s1),
		.result_in    (result),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.free         (out_free),
		.found        (found),
		.ipv4_address (ipv4_address),
		.status       (status)
	);

endmodule

### sv/dre_checker.sv
// Port-level checker for the DNS response IPv4 extractor, bound to the top level.
// Depends on dns_response_ipv4_extractor_unit_assert.svh.
`include "dns_response_ipv4_extractor_unit_assert.svh"

module dre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  byte_value,
	input logic        is_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [31:0] ipv4_address,
	input logic        status
);

	// a waiting result item holds until taken
	`DRE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(ipv4_address) && $stable(status))

	// no address without a type 1 answer
	`DRE_ASSERT_IMPL(a_addr_zero, clk, arst_n, out_valid && !found, ipv4_address == 32'd0)

	// input backpressure only comes from a stalled, full result register
	`DRE_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

bind dns_response_ipv4_extractor_unit dre_checker u_dre_checker (.*);
